@@ rtl/rms_sound_level_meter_assert.svh @@
// ----------------------------------------------------------------------------
// RMS sound level meter: assertion macros
// Immediate-consequence and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RMS_SOUND_LEVEL_METER_ASSERT_SVH
`define RMS_SOUND_LEVEL_METER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RSLM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rslm: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define RSLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rslm: next-cycle check failed");

`endif

@@ rtl/rslm_pkg.sv @@
// ----------------------------------------------------------------------------
// rslm_pkg
// Types and constants of the RMS sound level meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rslm_pkg;

   localparam int SUM_W     = 57;          // sum of squares
   localparam int MAG_W     = 24;          // sample magnitude
   localparam int SQ_W      = 47;          // one square
   localparam int M_W       = 31;          // Q1.30 mantissa
   localparam int FRAC_W    = 16;          // log2 fraction bits
   localparam int EXP_W     = 6;           // log2 integer part
   localparam int LOG_W     = EXP_W + FRAC_W;
   localparam int D_W       = 24;          // log difference, signed Q.16
   localparam int MUL_W     = 34;          // shared signed multiplier operands
   localparam int PROD_W    = 48;          // scaled level product
   localparam int CFG_W     = 15;
   localparam int LEVEL_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int COARSE    = 8;           // coarse normalize step
   localparam int NORM_TOP  = SUM_W - 1;
   localparam int KDB_W     = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE_OFFSET = 2'd1;

   localparam logic [CFG_W-1:0] THRESHOLD_RESET = 15'd256;
   localparam logic [CFG_W-1:0] OFFSET_RESET    = 15'd30720;

   // 10*log10(2) in Q16
   localparam logic [KDB_W-1:0] DB_PER_OCTAVE_Q16 = 18'd197283;
   // 46.0 in Q16: full-scale square is 2^46
   localparam logic signed [D_W-1:0] REF_LOG2_Q16 = 24'sd3014656;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 48'sd8388608;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_CHECK,
      ST_NORM,
      ST_LOG,
      ST_SCALE,
      ST_ROUND,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic signed [31:0] audio_word;
      logic               block_end;
   } req_item_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level_db;
      logic                      report;
      logic                      silent;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/rms_sound_level_meter.sv @@
// ----------------------------------------------------------------------------
// rms_sound_level_meter
// Block RMS level in Q8.8 dB with a report decision, one shared multiplier.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_item_type (audio_word, block_end)
//  rsp_      out        rsp_valid/rsp_stall  rsp_item_type (level_db, report, silent)
//  csr_      in         csr_we               csr_index, csr_wdata
//
//  Non-final sample: accept, square, add. Block end: accept, square, add, check,
//  then two log2 passes (normalize, then one squaring round per fraction bit;
//  first for the sum, then for the count), then scale, round and decide; an
//  all-zero block goes from check to decide. One shared 34x34 multiplier.
//  Reset is synchronous; req_stall is high while busy. A held result does
//  not block samples; only the next result waits for rsp_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rms_sound_level_meter_assert.svh"

module rms_sound_level_meter
   import rslm_pkg::*;
#(
   parameter int MAX_BLOCK = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK);
   localparam logic [3:0] LAST_ROUND = 4'(FRAC_W - 1);

   // control state
   state_type                  state_ff, state_in;
   logic [CFG_W-1:0]           thr_ff, thr_in;
   logic [CFG_W-1:0]           ofs_ff, ofs_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [LEVEL_W-1:0]  last_ff, last_in;
   logic                       have_ff, have_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       end_ff, end_in;
   logic                       take_ff, take_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [SUM_W-1:0]           norm_ff, norm_in;
   logic [EXP_W-1:0]           shift_ff, shift_in;
   logic [M_W-1:0]             m_ff, m_in;
   logic [FRAC_W-1:0]          frac_ff, frac_in;
   logic [3:0]                 round_ff, round_in;
   logic                       phase_ff, phase_in;
   logic [LOG_W-1:0]           lsum_ff, lsum_in;
   logic signed [D_W-1:0]      d_ff, d_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [LEVEL_W-1:0]  level_ff, level_in;
   logic                       silent_ff, silent_in;
   rsp_item_type               rsp_item_ff, rsp_item_in;

   // shared multiplier
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic signed [2*MUL_W-1:0]  mul_p;

   logic                       accept;
   logic                       out_free;
   logic                       decide_fire;
   logic [MAG_W-1:0]           u24;
   logic                       frac_bit;
   logic [M_W-1:0]             m_next;
   logic [FRAC_W-1:0]          frac_next;
   logic [LOG_W-1:0]           log_cur;
   logic signed [PROD_W-1:0]   rnd;
   logic signed [24:0]         lv;
   logic signed [LEVEL_W:0]    diff;
   logic [LEVEL_W:0]           absd;
   logic                       report;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mul_p    = mul_a * mul_b;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = end_ff ? ST_CHECK : ST_IDLE;
         ST_CHECK:  state_in = (sum_ff == '0) ? ST_DECIDE : ST_NORM;
         ST_NORM:   if (norm_ff[NORM_TOP]) state_in = ST_LOG;
         ST_LOG: begin
            if (round_ff == LAST_ROUND) state_in = phase_ff ? ST_SCALE : ST_NORM;
         end
         ST_SCALE:  state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_DECIDE;
         ST_DECIDE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      decide_fire = (state_ff == ST_DECIDE) && out_free;
      mul_a       = '0;
      mul_b       = '0;
      case (state_ff)
         ST_SQUARE: begin
            mul_a = {{(MUL_W-MAG_W){1'b0}}, mag_ff};
            mul_b = {{(MUL_W-MAG_W){1'b0}}, mag_ff};
         end
         ST_LOG: begin
            mul_a = {{(MUL_W-M_W){1'b0}}, m_ff};
            mul_b = {{(MUL_W-M_W){1'b0}}, m_ff};
         end
         ST_SCALE: begin
            mul_a = {{(MUL_W-D_W){d_ff[D_W-1]}}, d_ff};
            mul_b = {{(MUL_W-KDB_W){1'b0}}, DB_PER_OCTAVE_Q16};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      u24 = req_item.audio_word[31:8];

      // one squaring round of the log2 mantissa
      frac_bit  = mul_p[2*M_W-1];
      m_next    = frac_bit ? mul_p[2*M_W-1:M_W] : mul_p[2*M_W-2:M_W-1];
      frac_next = {frac_ff[FRAC_W-2:0], frac_bit};
      log_cur   = {EXP_W'(NORM_TOP) - shift_ff, frac_next};

      rnd  = prod_ff + ROUND_HALF;
      lv   = $signed({rnd[PROD_W-1], rnd[PROD_W-1:24]}) + $signed({10'b0, ofs_ff});
      diff = $signed({level_ff[LEVEL_W-1], level_ff}) - $signed({last_ff[LEVEL_W-1], last_ff});
      absd = diff[LEVEL_W] ? (LEVEL_W+1)'(-diff) : (LEVEL_W+1)'(diff);
      report = !have_ff || (absd >= {2'b00, thr_ff});

      thr_in       = thr_ff;
      ofs_in       = ofs_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      have_in      = have_ff;
      mag_in       = mag_ff;
      end_in       = end_ff;
      take_in      = take_ff;
      sq_in        = sq_ff;
      norm_in      = norm_ff;
      shift_in     = shift_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      round_in     = round_ff;
      phase_in     = phase_ff;
      lsum_in      = lsum_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      level_in     = level_ff;
      silent_in    = silent_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_we) begin
         case (csr_index)
            CSR_REPORT_THRESHOLD:  thr_in = csr_wdata;
            CSR_FULL_SCALE_OFFSET: ofs_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mag_in  = u24[MAG_W-1] ? (~u24 + 1'b1) : u24;
               end_in  = req_item.block_end;
               take_in = (cnt_ff < CNT_MAX);
            end
         end
         ST_SQUARE: sq_in = mul_p[SQ_W-1:0];
         ST_ACCUM: begin
            if (take_ff) begin
               sum_in = sum_ff + SUM_W'(sq_ff);
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            norm_in   = sum_ff;
            shift_in  = '0;
            phase_in  = 1'b0;
            silent_in = (sum_ff == '0);
            level_in  = '0;
         end
         ST_NORM: begin
            if (norm_ff[NORM_TOP]) begin
               m_in     = norm_ff[NORM_TOP -: M_W];
               frac_in  = '0;
               round_in = '0;
            end else if (norm_ff[NORM_TOP -: COARSE] == '0) begin
               norm_in  = norm_ff << COARSE;
               shift_in = shift_ff + EXP_W'(COARSE);
            end else begin
               norm_in  = norm_ff << 1;
               shift_in = shift_ff + 1'b1;
            end
         end
         ST_LOG: begin
            m_in     = m_next;
            frac_in  = frac_next;
            round_in = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               if (!phase_ff) begin
                  lsum_in  = log_cur;
                  norm_in  = SUM_W'(cnt_ff);
                  shift_in = '0;
                  phase_in = 1'b1;
               end else begin
                  d_in = $signed({2'b00, lsum_ff}) - $signed({2'b00, log_cur})
                         - REF_LOG2_Q16;
               end
            end
         end
         ST_SCALE: prod_in = mul_p[PROD_W-1:0];
         ST_ROUND: begin
            if (lv > 25'sd32767)
               level_in = 16'sh7FFF;
            else if (lv < -25'sd32768)
               level_in = -16'sh8000;
            else
               level_in = lv[LEVEL_W-1:0];
         end
         ST_DECIDE: begin
            if (decide_fire) begin
               rsp_item_in.level_db = level_ff;
               rsp_item_in.report   = report;
               rsp_item_in.silent   = silent_ff;
               rsp_valid_in         = 1'b1;
               sum_in               = '0;
               cnt_in               = '0;
               if (report) begin
                  last_in = level_ff;
                  have_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THRESHOLD_RESET;
         ofs_ff       <= OFFSET_RESET;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         last_ff      <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         ofs_ff       <= ofs_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      end_ff      <= end_in;
      take_ff     <= take_in;
      sq_ff       <= sq_in;
      norm_ff     <= norm_in;
      shift_ff    <= shift_in;
      m_ff        <= m_in;
      frac_ff     <= frac_in;
      round_ff    <= round_in;
      phase_ff    <= phase_in;
      lsum_ff     <= lsum_in;
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      level_ff    <= level_in;
      silent_ff   <= silent_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------------------------------------------------------- checks
   `RSLM_ASSERT_NEXT(a_accept_squares, clock, reset, accept, state_ff == ST_SQUARE)
   `RSLM_ASSERT_NOW(a_norm_nonzero, clock, reset, state_ff == ST_NORM, norm_ff != '0)
   `RSLM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_MAX)
   `RSLM_ASSERT_NEXT(a_decide_posts, clock, reset, decide_fire, rsp_valid_ff && cnt_ff == '0)
   `RSLM_ASSERT_NOW(a_silent_zero, clock, reset, rsp_valid_ff && rsp_item_ff.silent, rsp_item_ff.level_db == '0)

endmodule

`default_nettype wire

@@ tb/sv/tb_rms_sound_level_meter.sv @@
// ----------------------------------------------------------------------------
// tb_rms_sound_level_meter
// Self-checking bench for the block RMS level meter. Microphone words are
// streamed in blocks of random length and amplitude. A bit-accurate level
// predictor builds the expected level, report and silent flags for every
// block end. Results are checked in order, with random idle bursts on both
// channels and register settings changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rms_sound_level_meter;
   import rslm_pkg::*;

   localparam int    BLOCK_LIMIT    = 1024;
   localparam int    SETTLE_CYCLES  = 96;    // covers one block-end computation
   localparam longint DB_PER_OCT    = 197283; // 10*log10(2) in Q16
   localparam longint FULL_SCALE_L2 = 46;

   // indexes that decode to no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // amplitude classes for random blocks
   localparam int AMP_SILENT = 0;
   localparam int AMP_FULL   = 1;
   localparam int AMP_TINY   = 2;
   localparam int AMP_MID    = 3;
   localparam int AMP_ANY    = 4;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_item;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   rms_sound_level_meter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // level predictor state
   logic [CFG_W-1:0]          threshold_q = THRESHOLD_RESET;
   logic [CFG_W-1:0]          offset_q    = OFFSET_RESET;
   logic [SUM_W-1:0]          square_acc  = '0;
   logic [10:0]               block_count = '0;
   logic signed [LEVEL_W-1:0] last_reported = '0;
   logic                      reported_once = 1'b0;

   req_item_type sample_queue[$];
   rsp_item_type level_queue[$];

   int  fail_count = 0;
   int  samples_in = 0;
   int  blocks_checked = 0;
   int  reports_seen = 0;
   int  silent_seen = 0;
   int  settings_used = 1;
   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   int  req_gap = 0;
   int  rsp_hold = 0;
   bit  req_taken = 1'b0;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // log2 in Q.16 by repeated squaring of the Q1.30 mantissa
   function automatic logic [21:0] log2_fixed(input logic [63:0] x);
      logic [63:0] m;
      logic [5:0]  e;
      logic [15:0] frac;
      e = '0;
      for (int b = 0; b < 64; b++)
         if (x[b])
            e = b[5:0];
      if (e > 30)
         m = x >> (e - 30);
      else
         m = x << (30 - e);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = {frac[14:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {e, frac};
   endfunction

   function automatic logic signed [LEVEL_W-1:0] block_level_db(input logic [SUM_W-1:0] sum,
                                                               input logic [10:0] n,
                                                               input logic [CFG_W-1:0] ofs);
      longint      l_sum, l_cnt, d, p, q8, lv;
      logic [63:0] biased;
      l_sum  = log2_fixed({7'd0, sum});
      l_cnt  = log2_fixed({53'd0, n});
      d      = l_sum - l_cnt - (FULL_SCALE_L2 << 16);
      p      = d * DB_PER_OCT;
      biased = p + (longint'(1) << 23) + (longint'(1) << 50);
      q8     = longint'(biased >> 24) - (longint'(1) << 26);
      lv     = q8 + longint'(ofs);
      if (lv > 32767)
         lv = 32767;
      if (lv < -32768)
         lv = -32768;
      return lv[15:0];
   endfunction

   // fold one accepted item into the block; a block end yields one result
   function automatic void absorb_sample(input req_item_type it);
      logic [23:0]               s, mag;
      logic signed [LEVEL_W-1:0] level;
      logic                      silent, report;
      int                        diff;
      rsp_item_type              res;
      s   = it.audio_word[31:8];
      mag = s[23] ? (~s + 24'd1) : s;
      if (block_count < BLOCK_LIMIT) begin
         square_acc  = square_acc + {33'd0, mag} * {33'd0, mag};
         block_count = block_count + 11'd1;
      end
      if (!it.block_end)
         return;
      silent = (square_acc == 0) || (block_count == 0);
      level  = silent ? '0 : block_level_db(square_acc, block_count, offset_q);
      diff   = int'(level) - int'(last_reported);
      if (diff < 0)
         diff = -diff;
      report = !reported_once || (diff >= int'(threshold_q));
      if (report) begin
         last_reported = level;
         reported_once = 1'b1;
      end
      res.level_db = level;
      res.report   = report;
      res.silent   = silent;
      level_queue.push_back(res);
      square_acc  = '0;
      block_count = '0;
   endfunction

   // acceptance and result checking at the rising edge
   always @(posedge clock) begin
      rsp_item_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         absorb_sample(req_item);
         samples_in++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (level_queue.size() == 0) begin
            note_failure($sformatf("unexpected result level=%0d report=%0b silent=%0b",
                                   rsp_item.level_db, rsp_item.report, rsp_item.silent));
         end else begin
            want = level_queue.pop_front();
            blocks_checked++;
            reports_seen += want.report;
            silent_seen  += want.silent;
            if (rsp_item.level_db !== want.level_db || rsp_item.report !== want.report ||
                rsp_item.silent !== want.silent)
               note_failure($sformatf(
                  "block %0d: level exp %0d got %0d, report exp %0b got %0b, silent exp %0b got %0b",
                  blocks_checked, want.level_db, rsp_item.level_db, want.report,
                  rsp_item.report, want.silent, rsp_item.silent));
         end
      end
   end

   // item driver: holds a stalled item, otherwise idles in bursts or sends the next
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // item still waiting, keep it
      end else begin
         if (req_gap == 0 && sample_queue.size() > 0 && $urandom_range(99, 0) < req_idle_pct)
            req_gap = $urandom_range(16, 1);
         if (req_gap > 0 || sample_queue.size() == 0) begin
            req_valid <= 1'b0;
            if (req_gap > 0)
               req_gap--;
         end else begin
            req_item  <= sample_queue.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // result back-pressure in bursts
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else if ($urandom_range(99, 0) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         rsp_hold = $urandom_range(15, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void add_sample(input logic [31:0] word, input logic last);
      req_item_type it;
      it.audio_word = word;
      it.block_end  = last;
      sample_queue.push_back(it);
   endfunction

   function automatic logic [31:0] pick_word(input int amp);
      logic [23:0] s;
      logic [7:0]  low;
      low = 8'($urandom_range(255, 0));
      case (amp)
         AMP_SILENT: return {24'd0, low};
         AMP_FULL:   s = $urandom_range(1, 0) ? 24'h800000 : 24'h7FFFFF;
         AMP_TINY:   s = 24'($urandom_range(8, 0)) - 24'd4;
         AMP_MID:    s = {{8{1'b0}}, 16'($urandom)} - 24'h8000;
         default:    return $urandom;
      endcase
      return {s, low};
   endfunction

   function automatic int add_block(input int len, input int amp);
      for (int i = 0; i < len; i++)
         add_sample(pick_word(amp), i == len - 1);
      return len;
   endfunction

   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_valid || level_queue.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_REPORT_THRESHOLD:  threshold_q = data;
         CSR_FULL_SCALE_OFFSET: offset_q    = data;
         default: ;
      endcase
   endtask

   // one register setting followed by random blocks
   task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] ofs,
                            input int n_items, input int req_pct, input int rsp_pct,
                            input bit overlong);
      int queued;
      int amp;
      wait_idle();
      write_reg(CSR_REPORT_THRESHOLD, thr);
      write_reg(CSR_FULL_SCALE_OFFSET, ofs);
      write_reg($urandom_range(1, 0) ? CSR_SPARE_2 : CSR_SPARE_3, 15'($urandom));
      settings_used++;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      queued = 0;
      if (overlong)
         queued += add_block(BLOCK_LIMIT + $urandom_range(6, 1), $urandom_range(AMP_ANY, AMP_FULL));
      while (queued < n_items) begin
         // each block draws its samples from one randomly chosen amplitude class
         amp = $urandom_range(AMP_ANY, AMP_SILENT);
         if ($urandom_range(9, 0) == 0)
            queued += add_block($urandom_range(40, 9), amp);
         else
            queued += add_block($urandom_range(8, 1), amp);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed blocks at reset register values
      req_idle_pct = 15;
      rsp_idle_pct = 15;
      add_sample(32'h0000_0000, 1'b1);   // silent first block, reported
      add_sample(32'h8000_0000, 1'b1);   // most negative sample
      add_sample(32'h7FFF_FF00, 1'b1);   // most positive, level nearly unchanged
      add_sample(32'h0000_00FF, 1'b1);   // only the dropped low byte set
      add_sample(32'h0000_0100, 1'b1);   // smallest nonzero sample
      add_sample(32'hFFFF_FFFF, 1'b1);   // -1, same level as +1
      add_sample(32'h1234_5678, 1'b0);
      add_sample(32'hFFFF_FF80, 1'b0);
      add_sample(32'h0000_0000, 1'b0);
      add_sample(32'h7FFF_FFFF, 1'b1);
      add_sample(32'h0000_00FF, 1'b0);
      add_sample(32'h0000_0080, 1'b0);
      add_sample(32'h0000_00FF, 1'b1);
      for (int i = 0; i < 8; i++)
         add_sample(i[0] ? 32'h7FFF_FF00 : 32'h8000_0000, i == 7);

      run_phase(15'd0, 15'd32767, 130, 10, 10, 1'b0);
      run_phase(15'd32767, 15'd0, 130, 30, 40, 1'b1);
      run_phase(15'($urandom_range(1023, 0)), 15'($urandom), 130, 0, 0, 1'b0);
      run_phase(15'($urandom_range(512, 1)), OFFSET_RESET, 130, 5, 60, 1'b0);
      run_phase(15'($urandom), 15'($urandom), 130, 40, 5, 1'b0);
      run_phase(THRESHOLD_RESET, 15'($urandom), 130, 0, 0, 1'b0);

      wait_idle();
      $display("Ran %0d samples, %0d block results checked over %0d register settings",
               samples_in, blocks_checked, settings_used);
      $display("Results included %0d reports and %0d silent blocks; %0d failures",
               reports_seen, silent_seen, fail_count);
      if (fail_count == 0 && level_queue.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #4ms;
      $display("Timeout: %0d results still expected", level_queue.size());
      $display("Verification failed");
      $finish;
   end

endmodule
